@@ rtl/lrb_pkg.sv @@
// lrb_pkg: shared constants, codes and types of the live range builder
// no dependencies; imported by live_range_builder and lrb_table
`default_nettype none

package lrb_pkg;

    localparam int VREG_COUNT    = 32;
    localparam int POSITION_BITS = 16;
    localparam int VIDX_W        = $clog2(VREG_COUNT);
    localparam int ENTRY_W       = 2 * POSITION_BITS;

    // event operation codes
    localparam logic [1:0] OP_BEGIN = 2'd0;
    localparam logic [1:0] OP_END   = 2'd1;
    localparam logic [1:0] OP_DEF   = 2'd2;
    localparam logic [1:0] OP_USE   = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_RANGE  = 2'd0;
    localparam logic [1:0] KIND_ERROR  = 2'd1;
    localparam logic [1:0] KIND_CLOSED = 2'd2;

    typedef logic [POSITION_BITS-1:0] pos_t;
    typedef logic [VIDX_W-1:0]        vidx_t;

    typedef struct packed {
        pos_t start_pos;
        pos_t end_pos;
    } entry_t;

    typedef struct packed {
        logic   rd_en;
        logic   wr_en;
        logic   clear_all;
        vidx_t  addr;
        entry_t wr_entry;
    } tbl_req_t;

endpackage

`default_nettype wire

@@ rtl/lrb_in_if.sv @@
// lrb_in_if: valid/ready channel carrying one register event
// no dependencies
`default_nettype none

interface lrb_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [15:0] position;
    logic [4:0]  vreg_number;

    modport source (output valid, output operation, output position, output vreg_number,
                    input ready);
    modport sink (input valid, input operation, input position, input vreg_number,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/lrb_out_if.sv @@
// lrb_out_if: valid/ready channel carrying one live range result
// no dependencies
`default_nettype none

interface lrb_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [4:0]  range_vreg;
    logic [15:0] range_start;
    logic [15:0] range_end;
    logic        last_of_run;

    modport source (output valid, output result_kind, output range_vreg,
                    output range_start, output range_end, output last_of_run,
                    input ready);
    modport sink (input valid, input result_kind, input range_vreg,
                  input range_start, input range_end, input last_of_run,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/live_range_builder.sv @@
// live_range_builder: top level, event sequencer and result register
// depends on lrb_pkg, lrb_in_if, lrb_out_if and lrb_table
//
// Builds live ranges from a stream of register events. Definitions and uses
// first read the register's entry from the single-port pending table, then
// emit a result or write the entry back, or both. A region end walks the
// whole table through that same port, reading and then checking each
// register, and then emits the closing marker. A state with a result due
// waits while the result register is still held by the sink. The table
// clears at reset and after every region end.
`default_nettype none

module live_range_builder
    import lrb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    lrb_in_if.sink    events,
    lrb_out_if.source results
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXEC   = 3'd1;
    localparam logic [2:0] ST_FL_RD  = 3'd2;
    localparam logic [2:0] ST_FL_CHK = 3'd3;
    localparam logic [2:0] ST_MARK   = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic        region_open_reg, region_open_next;
    logic [1:0]  op_reg, op_next;
    pos_t        pos_reg, pos_next;
    vidx_t       vidx_reg, vidx_next;
    vidx_t       idx_reg, idx_next;

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  out_kind_reg, out_kind_next;
    logic [4:0]  out_vreg_reg, out_vreg_next;
    logic [15:0] out_start_reg, out_start_next;
    logic [15:0] out_end_reg, out_end_next;
    logic        out_last_reg, out_last_next;

    tbl_req_t    req;
    entry_t      entry;
    logic        accept;
    logic        out_free;
    logic        in_range;

    lrb_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rd_entry (entry)
    );

    assign events.ready = (state_reg == ST_IDLE);
    assign accept       = events.valid && events.ready;
    assign out_free     = !out_valid_reg || results.ready;
    assign in_range     = 32'(events.vreg_number) < VREG_COUNT;

    always_comb
    begin
        state_next       = state_reg;
        region_open_next = region_open_reg;
        op_next          = op_reg;
        pos_next         = pos_reg;
        vidx_next        = vidx_reg;
        idx_next         = idx_reg;

        out_valid_next = out_valid_reg && !results.ready;
        out_kind_next  = out_kind_reg;
        out_vreg_next  = out_vreg_reg;
        out_start_next = out_start_reg;
        out_end_next   = out_end_reg;
        out_last_next  = out_last_reg;

        req = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                req.addr = VIDX_W'(events.vreg_number);
                if (accept)
                begin
                    if (events.operation == OP_BEGIN)
                    begin
                        region_open_next = 1'b1;
                    end
                    else if (region_open_reg)
                    begin
                        if (events.operation == OP_END)
                        begin
                            idx_next   = '0;
                            state_next = ST_FL_RD;
                        end
                        else if (in_range)
                        begin
                            req.rd_en  = 1'b1;
                            op_next    = events.operation;
                            pos_next   = POSITION_BITS'(events.position);
                            vidx_next  = VIDX_W'(events.vreg_number);
                            state_next = ST_EXEC;
                        end
                    end
                end
            end

            ST_EXEC:
            begin
                req.addr = vidx_reg;
                if (op_reg == OP_DEF)
                begin
                    if (out_free || entry.end_pos == '0)
                    begin
                        if (entry.end_pos != '0)
                        begin
                            out_valid_next = 1'b1;
                            out_kind_next  = KIND_RANGE;
                            out_vreg_next  = 5'(vidx_reg);
                            out_start_next = 16'(entry.start_pos);
                            out_end_next   = 16'(entry.end_pos);
                            out_last_next  = 1'b1;
                        end
                        req.wr_en    = 1'b1;
                        req.wr_entry = '{start_pos: pos_reg, end_pos: pos_reg};
                        state_next   = ST_IDLE;
                    end
                end
                else if (entry.start_pos == '0)
                begin
                    // use before def
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_kind_next  = KIND_ERROR;
                        out_vreg_next  = 5'(vidx_reg);
                        out_start_next = '0;
                        out_end_next   = '0;
                        out_last_next  = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    req.wr_en    = 1'b1;
                    req.wr_entry = '{start_pos: entry.start_pos, end_pos: pos_reg};
                    state_next   = ST_IDLE;
                end
            end

            ST_FL_RD:
            begin
                req.addr   = idx_reg;
                req.rd_en  = 1'b1;
                state_next = ST_FL_CHK;
            end

            ST_FL_CHK:
            begin
                req.addr = idx_reg;
                if (out_free || entry.end_pos == '0)
                begin
                    if (entry.end_pos != '0)
                    begin
                        out_valid_next = 1'b1;
                        out_kind_next  = KIND_RANGE;
                        out_vreg_next  = 5'(idx_reg);
                        out_start_next = 16'(entry.start_pos);
                        out_end_next   = 16'(entry.end_pos);
                        out_last_next  = 1'b0;
                    end
                    if (idx_reg == VIDX_W'(VREG_COUNT - 1))
                    begin
                        state_next = ST_MARK;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_FL_RD;
                    end
                end
            end

            ST_MARK:
            begin
                req.addr = idx_reg;
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_kind_next    = KIND_CLOSED;
                    out_vreg_next    = '0;
                    out_start_next   = '0;
                    out_end_next     = '0;
                    out_last_next    = 1'b1;
                    req.clear_all    = 1'b1;
                    region_open_next = 1'b0;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            region_open_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            idx_reg         <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            region_open_reg <= region_open_next;
            out_valid_reg   <= out_valid_next;
            idx_reg         <= idx_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        pos_reg       <= pos_next;
        vidx_reg      <= vidx_next;
        out_kind_reg  <= out_kind_next;
        out_vreg_reg  <= out_vreg_next;
        out_start_reg <= out_start_next;
        out_end_reg   <= out_end_next;
        out_last_reg  <= out_last_next;
    end

    assign results.valid       = out_valid_reg;
    assign results.result_kind = out_kind_reg;
    assign results.range_vreg  = out_vreg_reg;
    assign results.range_start = out_start_reg;
    assign results.range_end   = out_end_reg;
    assign results.last_of_run = out_last_reg;

endmodule

`default_nettype wire

@@ rtl/lrb_ram.sv @@
// lrb_ram: generic single-port-write, single-read ram with registered read
// no dependencies
`default_nettype none

module lrb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/lrb_table.sv @@
// lrb_table: pending range table, ram plus per-entry valid bits
// depends on lrb_pkg and lrb_ram; invalid entries read as zero
`default_nettype none

module lrb_table
    import lrb_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire tbl_req_t req,
    output entry_t        rd_entry
);

    logic [VREG_COUNT-1:0] valid_reg;
    logic [VREG_COUNT-1:0] valid_next;
    logic                  hit_reg;
    logic                  hit_next;
    logic [ENTRY_W-1:0]    ram_q;

    lrb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (VREG_COUNT)
    ) u_ram (
        .clk     (clk),
        .wr_en   (req.wr_en),
        .wr_addr (req.addr),
        .wr_data (req.wr_entry),
        .rd_en   (req.rd_en),
        .rd_addr (req.addr),
        .rd_data (ram_q)
    );

    always_comb
    begin
        valid_next = valid_reg;
        hit_next   = hit_reg;
        if (req.rd_en)
        begin
            hit_next = valid_reg[req.addr];
        end
        if (req.clear_all)
        begin
            valid_next = '0;
        end
        else if (req.wr_en)
        begin
            valid_next[req.addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            hit_reg   <= hit_next;
        end
    end

    assign rd_entry = hit_reg ? entry_t'(ram_q) : '0;

endmodule

`default_nettype wire

@@ tb/sv/live_range_builder_test.sv @@
// live_range_builder_test: self-checking testbench of the live range builder
// depends on lrb_pkg, lrb_in_if, lrb_out_if and the live_range_builder rtl
// predicts every result of each event transfer and compares them in order
`timescale 1ns / 100ps

module live_range_builder_test
    import lrb_pkg::*;
();

    localparam int ITEM_TARGET   = 430;
    localparam int SETTLE_CYCLES = 2 * VREG_COUNT + 16;
    localparam logic [7:0] READY_PATTERN = 8'b1011_0110;

    typedef struct packed {
        logic [1:0] result_kind;
        vidx_t      range_vreg;
        pos_t       range_start;
        pos_t       range_end;
        logic       last_of_run;
    } range_rec_t;

    logic clk;
    logic rst_n;

    lrb_in_if  event_ch ();
    lrb_out_if result_ch ();

    live_range_builder i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .events  (event_ch),
        .results (result_ch)
    );

    pos_t       start_at [VREG_COUNT];
    pos_t       end_at [VREG_COUNT];
    bit         in_region;
    range_rec_t ranges_due [$];
    range_rec_t front_range;
    int         items_taken;
    int         mismatches;
    int         burst_left;
    int         ready_mode;
    int         ready_mode_left;
    int         ready_cycle;
    int         stall_left;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("live_range_builder regression: fail");
        $finish;
    end

    function automatic void add_result(logic [1:0] kind, vidx_t v, pos_t s, pos_t e);
        range_rec_t rec;
        rec.result_kind = kind;
        rec.range_vreg  = v;
        rec.range_start = s;
        rec.range_end   = e;
        rec.last_of_run = 1'b0;
        ranges_due.push_back(rec);
    endfunction

    // returns 0 when the block ignores the event
    function automatic bit track_event(logic [1:0] op, pos_t pos, vidx_t v);
        bit         took;
        int         n;
        range_rec_t rec;
        took = 1'b1;
        n = 0;
        if (op == OP_BEGIN)
        begin
            in_region = 1'b1;
        end
        else if (!in_region)
        begin
            took = 1'b0;
        end
        else if (op == OP_END)
        begin
            for (int r = 0; r < VREG_COUNT; r++)
            begin
                if (end_at[r] != '0)
                begin
                    add_result(KIND_RANGE, vidx_t'(r), start_at[r], end_at[r]);
                    n++;
                end
                start_at[r] = '0;
                end_at[r] = '0;
            end
            add_result(KIND_CLOSED, '0, '0, '0);
            n++;
            in_region = 1'b0;
        end
        else if (int'(v) >= VREG_COUNT)
        begin
            took = 1'b0;
        end
        else if (op == OP_DEF)
        begin
            if (end_at[v] != '0)
            begin
                add_result(KIND_RANGE, v, start_at[v], end_at[v]);
                n++;
            end
            start_at[v] = pos;
            end_at[v] = pos;
        end
        else if (start_at[v] == '0)
        begin
            add_result(KIND_ERROR, v, '0, '0);
            n++;
        end
        else
        begin
            end_at[v] = pos;
        end
        if (n > 0)
        begin
            rec = ranges_due.pop_back();
            rec.last_of_run = 1'b1;
            ranges_due.push_back(rec);
        end
        return took;
    endfunction

    task automatic send_event(logic [1:0] op, pos_t pos, vidx_t v);
        event_ch.valid       <= 1'b1;
        event_ch.operation   <= op;
        event_ch.position    <= pos;
        event_ch.vreg_number <= v;
        @(posedge clk);
        while (!event_ch.ready)
            @(posedge clk);
        if (track_event(op, pos, v))
            items_taken++;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            event_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(0, 8);
        end
    endtask

    task automatic settle_results();
        event_ch.valid <= 1'b0;
        while (ranges_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_idle_events();
        send_event(OP_END, 16'h0000, 5'd0);
        send_event(OP_DEF, 16'h0001, 5'd3);
        send_event(OP_USE, 16'h0002, 5'd3);
        send_event(OP_DEF, 16'hFFFF, 5'd31);
        send_event(OP_USE, 16'h8000, 5'd17);
    endtask

    task automatic test_directed_ranges();
        send_event(OP_BEGIN, 16'h0000, 5'd0);
        send_event(OP_BEGIN, 16'hFFFF, 5'd31);
        send_event(OP_USE,   16'h1234, 5'd5);
        send_event(OP_DEF,   16'h0001, 5'd0);
        send_event(OP_USE,   16'hFFFF, 5'd0);
        send_event(OP_DEF,   16'hFFFF, 5'd31);
        send_event(OP_DEF,   16'h0000, 5'd7);
        send_event(OP_USE,   16'h0040, 5'd7);
        send_event(OP_DEF,   16'h0100, 5'd9);
        send_event(OP_USE,   16'h0000, 5'd9);
        send_event(OP_DEF,   16'h0200, 5'd9);
        send_event(OP_DEF,   16'h5555, 5'd0);
        send_event(OP_USE,   16'hAAAA, 5'd0);
        send_event(OP_USE,   16'h0300, 5'd21);
        send_event(OP_DEF,   16'h002A, 5'd10);
        send_event(OP_END,   16'h0000, 5'd0);
        send_event(OP_BEGIN, 16'h7FFF, 5'd14);
        send_event(OP_END,   16'hFFFF, 5'd31);
    endtask

    task automatic test_full_table();
        pos_t at;
        int   k;
        at = pos_t'($urandom_range(1, 30000));
        k = $urandom_range(0, VREG_COUNT - 1);
        send_event(OP_BEGIN, '0, '0);
        for (int r = 0; r < VREG_COUNT; r++)
        begin
            at = at + pos_t'($urandom_range(1, 9));
            send_event(OP_DEF, at, vidx_t'((r * 7 + k) % VREG_COUNT));
        end
        send_event(OP_END, '0, '0);
    endtask

    task automatic test_random_regions();
        int    span;
        int    base;
        int    events_n;
        int    pick;
        pos_t  at;
        vidx_t v;
        while (items_taken < ITEM_TARGET)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                repeat ($urandom_range(1, 4))
                    send_event(2'($urandom_range(0, 3)), pos_t'($urandom), vidx_t'($urandom));
            end
            else
            begin
                send_event(OP_BEGIN, pos_t'($urandom), vidx_t'($urandom));
                span = ($urandom_range(0, 5) == 0) ? VREG_COUNT : $urandom_range(1, 8);
                base = $urandom_range(0, VREG_COUNT - 1);
                events_n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 45)
                                                       : $urandom_range(1, 12);
                at = pos_t'($urandom_range(1, 65535));
                repeat (events_n)
                begin
                    at = at + pos_t'($urandom_range(0, 24));
                    v = vidx_t'((base + $urandom_range(0, span - 1)) % VREG_COUNT);
                    pick = $urandom_range(0, 19);
                    if (pick < 11)
                        send_event(OP_DEF, at, v);
                    else if (pick < 18)
                        send_event(OP_USE, at, v);
                    else if (pick == 18)
                        send_event(2'($urandom_range(0, 3)),
                                   $urandom_range(0, 1) ? pos_t'(0) : pos_t'($urandom), v);
                    else
                        send_event(OP_BEGIN, at, v);
                end
                if ($urandom_range(0, 11) != 0)
                    send_event(OP_END, pos_t'($urandom), vidx_t'($urandom));
                if ($urandom_range(0, 14) == 0)
                    settle_results();
            end
        end
    endtask

    // result side stalls
    initial
    begin
        ready_mode_left = 0;
        ready_cycle = 0;
        stall_left = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (ready_mode_left == 0)
            begin
                ready_mode = $urandom_range(0, 3);
                ready_mode_left = $urandom_range(20, 120);
            end
            ready_mode_left--;
            ready_cycle++;
            case (ready_mode)
                0: result_ch.ready <= 1'b1;
                1: result_ch.ready <= ($urandom_range(0, 3) != 0);
                2: result_ch.ready <= READY_PATTERN[ready_cycle % 8];
                default:
                begin
                    if (stall_left > 0)
                    begin
                        stall_left--;
                        result_ch.ready <= 1'b0;
                    end
                    else
                    begin
                        result_ch.ready <= 1'b1;
                        if ($urandom_range(0, 4) == 0)
                            stall_left = $urandom_range(1, 4);
                    end
                end
            endcase
        end
    end

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (ranges_due.size() == 0)
            begin
                $display("%0t: unexpected result, actual kind %0d vreg %0d %0h..%0h last %0b",
                         $time, result_ch.result_kind, result_ch.range_vreg,
                         result_ch.range_start, result_ch.range_end, result_ch.last_of_run);
                mismatches++;
            end
            else
            begin
                front_range = ranges_due.pop_front();
                check_field("result_kind", 32'(front_range.result_kind),
                            32'(result_ch.result_kind));
                check_field("range_vreg", 32'(front_range.range_vreg),
                            32'(result_ch.range_vreg));
                check_field("range_start", 32'(front_range.range_start),
                            32'(result_ch.range_start));
                check_field("range_end", 32'(front_range.range_end),
                            32'(result_ch.range_end));
                check_field("last_of_run", 32'(front_range.last_of_run),
                            32'(result_ch.last_of_run));
            end
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        event_ch.valid       <= 1'b0;
        event_ch.operation   <= OP_BEGIN;
        event_ch.position    <= '0;
        event_ch.vreg_number <= '0;
        for (int r = 0; r < VREG_COUNT; r++)
        begin
            start_at[r] = '0;
            end_at[r] = '0;
        end
        in_region = 1'b0;
        items_taken = 0;
        mismatches = 0;
        burst_left = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_events();
        settle_results();
        test_directed_ranges();
        settle_results();
        test_full_table();
        settle_results();
        test_random_regions();
        settle_results();

        if (mismatches == 0)
            $display("live_range_builder regression: pass");
        else
            $display("live_range_builder regression: fail");
        $finish;
    end

endmodule
